// ----- sv/usd_pkg.sv -----
// Shared types and constants of the UTF-8 stream decoder.
package usd_pkg;

	localparam int unsigned CP_W = 21;

	localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
	localparam logic [CP_W-1:0] SURR_LO     = 21'h00D800;
	localparam logic [CP_W-1:0] SURR_HI     = 21'h00DFFF;
	localparam logic [CP_W-1:0] MIN_LEN2    = 21'h000080;
	localparam logic [CP_W-1:0] MIN_LEN3    = 21'h000800;
	localparam logic [CP_W-1:0] MIN_LEN4    = 21'h010000;
	localparam logic [CP_W-1:0] REPL_RESET  = 21'h00FFFD;

	// Input word: one raw byte and the end-of-text flag.
	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} usd_in_t;

	// Output word: one code point and its flags.
	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            is_replacement;
		logic            run_last;
		logic            text_end;
	} usd_out_t;

	// Command from front to back: replacements first, then an optional code point.
	typedef struct packed {
		logic [2:0]      rep_count;
		logic            has_cp;
		logic [CP_W-1:0] cp;
		logic            last;
	} usd_cmd_t;

endpackage

// ----- sv/usd_front.sv -----
// Front end: accepts bytes, tracks the open sequence and issues output commands.
module usd_front
	import usd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     byte_valid,
	output logic     byte_ready,
	input  usd_in_t  byte_data,
	input  logic     q_full,
	output logic     push,
	output usd_cmd_t push_cmd,
	output logic     pending
);

	logic [2:0]      seq_len_q;
	logic [1:0]      cont_q;
	logic [CP_W-1:0] acc_q;

	logic [2:0]      seq_len_d;
	logic [1:0]      cont_d;
	logic [CP_W-1:0] acc_d;

	logic [7:0]      b;
	logic            is_cont;
	logic [1:0]      cont_new;
	logic [CP_W-1:0] acc_new;
	logic            complete;
	logic [CP_W-1:0] lowest;
	logic            scalar_ok;
	logic            opened;
	logic            accept;

	assign b          = byte_data.in_byte;
	assign is_cont    = (b[7:6] == 2'b10);
	assign cont_new   = cont_q + 2'd1;
	assign acc_new    = {acc_q[CP_W-7:0], b[5:0]};
	assign complete   = (({1'b0, cont_new} + 3'd1) >= seq_len_q);
	assign pending    = (seq_len_q != 3'd0);
	assign byte_ready = !q_full;
	assign accept     = byte_valid && byte_ready;

	// Minimum value per sequence length rejects overlong forms.
	always_comb begin
		unique case (seq_len_q)
			3'd2:    lowest = MIN_LEN2;
			3'd3:    lowest = MIN_LEN3;
			default: lowest = MIN_LEN4;
		endcase
	end

	assign scalar_ok = (acc_new >= lowest) && (acc_new <= CP_MAX) &&
		!((acc_new >= SURR_LO) && (acc_new <= SURR_HI));

	// Classify the byte and build the command and next state.
	always_comb begin
		seq_len_d          = seq_len_q;
		cont_d             = cont_q;
		acc_d              = acc_q;
		opened             = 1'b0;
		push_cmd.rep_count = 3'd0;
		push_cmd.has_cp    = 1'b0;
		push_cmd.cp        = acc_new;
		push_cmd.last      = byte_data.in_last;
		if (pending && is_cont) begin
			if (complete) begin
				if (scalar_ok) begin
					push_cmd.has_cp = 1'b1;
				end else begin
					push_cmd.rep_count = seq_len_q;
				end
				seq_len_d = 3'd0;
				cont_d    = 2'd0;
				acc_d     = '0;
			end else if (byte_data.in_last) begin
				push_cmd.rep_count = {1'b0, cont_new} + 3'd1;
				seq_len_d          = 3'd0;
				cont_d             = 2'd0;
				acc_d              = '0;
			end else begin
				cont_d = cont_new;
				acc_d  = acc_new;
			end
		end else begin
			// Flush an interrupted sequence, then treat the byte as a lead.
			if (pending) begin
				push_cmd.rep_count = {1'b0, cont_q} + 3'd1;
			end
			seq_len_d = 3'd0;
			cont_d    = 2'd0;
			acc_d     = '0;
			priority if (b[7] == 1'b0) begin
				push_cmd.has_cp = 1'b1;
				push_cmd.cp     = {{(CP_W-8){1'b0}}, b};
			end else if (b[7:5] == 3'b110) begin
				opened    = 1'b1;
				seq_len_d = 3'd2;
				acc_d     = {{(CP_W-5){1'b0}}, b[4:0]};
			end else if (b[7:4] == 4'b1110) begin
				opened    = 1'b1;
				seq_len_d = 3'd3;
				acc_d     = {{(CP_W-4){1'b0}}, b[3:0]};
			end else if (b[7:3] == 5'b11110) begin
				opened    = 1'b1;
				seq_len_d = 3'd4;
				acc_d     = {{(CP_W-3){1'b0}}, b[2:0]};
			end else begin
				push_cmd.rep_count = push_cmd.rep_count + 3'd1;
			end
			// Truncated text: drop the lead just opened as one replacement.
			if (opened && byte_data.in_last) begin
				push_cmd.rep_count = push_cmd.rep_count + 3'd1;
				seq_len_d          = 3'd0;
				acc_d              = '0;
			end
		end
	end

	assign push = accept && ((push_cmd.rep_count != 3'd0) || push_cmd.has_cp);

	// Advance the sequence state on each accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_len_q <= 3'd0;
			cont_q    <= 2'd0;
			acc_q     <= '0;
		end else if (accept) begin
			seq_len_q <= seq_len_d;
			cont_q    <= cont_d;
			acc_q     <= acc_d;
		end
	end

endmodule

// ----- sv/usd_queue.sv -----
// Short command queue between the front and back ends.
module usd_queue
	import usd_pkg::*;
#(
	parameter int unsigned DEPTH = 2
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  usd_cmd_t push_cmd,
	input  logic     pop,
	output logic     head_valid,
	output usd_cmd_t head_cmd,
	output logic     full
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	usd_cmd_t         entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign head_valid = (count_q != '0);
	assign full       = (count_q == FULL_CNT);
	assign head_cmd   = entry_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	// Store the pushed command.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ----- sv/usd_back.sv -----
// Back end: expands each command into code points through an output register.
module usd_back
	import usd_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  usd_cmd_t        head_cmd,
	output logic            pop,
	input  logic [CP_W-1:0] repl_code,
	output logic            cp_valid,
	input  logic            cp_ready,
	output usd_out_t        cp_data
);

	logic [1:0]      idx_q;
	logic            out_valid_q;
	usd_out_t        out_q;
	logic [2:0]      total;
	logic            last_item;
	logic            is_rep;
	logic            load;

	assign total     = head_cmd.rep_count + {2'b00, head_cmd.has_cp};
	assign last_item = (({1'b0, idx_q} + 3'd1) == total);
	assign is_rep    = ({1'b0, idx_q} < head_cmd.rep_count);
	assign load      = head_valid && (!out_valid_q || cp_ready);
	assign pop       = load && last_item;

	// Step through the items of the head command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= last_item ? 2'd0 : idx_q + 2'd1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (cp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load the output word.
	always_ff @(posedge clk) begin
		if (load) begin
			out_q.code_point     <= is_rep ? repl_code : head_cmd.cp;
			out_q.is_replacement <= is_rep;
			out_q.run_last       <= last_item;
			out_q.text_end       <= last_item && head_cmd.last;
		end
	end

	assign cp_valid = out_valid_q;
	assign cp_data  = out_q;

endmodule

// ----- sv/utf8_stream_decoder.sv -----
// Top level of the UTF-8 stream decoder: front end, command queue, back end.
//
//   channel  | direction | handshake            | word
//   ---------+-----------+----------------------+----------------------------
//   byte     | in        | byte_valid/ready     | usd_in_t  (in_byte, in_last)
//   cp       | out       | cp_valid/ready       | usd_out_t (code point, flags)
//   cfg      | in        | cfg_we               | cfg_wdata, replacement code
//
// A byte is accepted each cycle while the queue has room; the front end
// decides in that cycle how many code points the byte causes (zero to four).
// The back end emits one code point per cycle while cp_ready is high, so a
// byte causing n code points occupies it until all n are sent; QUEUE_DEPTH
// commands buffer bursts between the two. Each command is registered in the
// queue and then in the output register. Reset clears sequence state, the
// queue and the output valid flag, and sets the replacement code to U+FFFD.
module utf8_stream_decoder
	import usd_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            byte_valid,
	output logic            byte_ready,
	input  usd_in_t         byte_data,
	output logic            cp_valid,
	input  logic            cp_ready,
	output usd_out_t        cp_data,
	input  logic            cfg_we,
	input  logic [CP_W-1:0] cfg_wdata
);

	logic [CP_W-1:0] repl_q;
	logic            q_full;
	logic            push;
	usd_cmd_t        push_cmd;
	logic            pending;
	logic            pop;
	logic            head_valid;
	usd_cmd_t        head_cmd;

	// Hold the replacement code register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repl_q <= REPL_RESET;
		end else if (cfg_we) begin
			repl_q <= cfg_wdata;
		end
	end

	usd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_data (byte_data),
		.q_full    (q_full),
		.push      (push),
		.push_cmd  (push_cmd),
		.pending   (pending)
	);

	usd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (pop),
		.head_valid(head_valid),
		.head_cmd  (head_cmd),
		.full      (q_full)
	);

	usd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_cmd  (head_cmd),
		.pop       (pop),
		.repl_code (repl_q),
		.cp_valid  (cp_valid),
		.cp_ready  (cp_ready),
		.cp_data   (cp_data)
	);

`ifndef NO_ASSERTIONS
	// A decoded code point is always a Unicode scalar value.
	a_scalar_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cp_valid && !cp_data.is_replacement) |->
		((cp_data.code_point <= CP_MAX) &&
		 !((cp_data.code_point >= SURR_LO) && (cp_data.code_point <= SURR_HI))))
		else $error("decoded code point is not a scalar value");

	// End of text is always the last word of its byte.
	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cp_valid && cp_data.text_end) |-> cp_data.run_last)
		else $error("text_end without run_last");

	// After the final byte of a text no sequence stays open.
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_valid && byte_ready && byte_data.in_last) |=> !pending)
		else $error("sequence still open after final byte");
`endif

endmodule
